// ===== design/slcan_ascii_frame_parser_defines.svh =====
// ---------------------------------------------------------------------------
// Serial CAN line parser assertion macros
// Shared shorthand for the concurrent checks on clk and arst_n.
// ---------------------------------------------------------------------------
`ifndef SLCAN_ASCII_FRAME_PARSER_DEFINES_SVH
`define SLCAN_ASCII_FRAME_PARSER_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define SLCANFP_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define SLCANFP_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/slcanfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial CAN line parser package
// Character codes, frame kind codes, the result type and the hex decoder.
// ---------------------------------------------------------------------------
package slcanfp_pkg;

	// Characters the parser reacts to
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_T_UP = 8'h54;
	localparam logic [7:0] CH_R_UP = 8'h52;
	localparam logic [7:0] CH_T_LO = 8'h74;
	localparam logic [7:0] CH_R_LO = 8'h72;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_8    = 8'h38;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_F_UP = 8'h46;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_F_LO = 8'h66;

	// Frame kind taken from the type letter
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_STD  = 2'd1;
	localparam logic [1:0] KIND_EXT  = 2'd2;

	localparam int unsigned NUM_DATA = 8;

	typedef logic [NUM_DATA-1:0][7:0] data_bytes_t;

	// One decoded frame
	typedef struct packed {
		logic        ext_id;
		logic [31:0] frame_id;
		logic [3:0]  data_length;
		data_bytes_t data_bytes;
		logic [31:0] frames_seen;
	} result_t;

	// Bit 4 flags a hex digit, bits 3..0 carry its value
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

// ===== design/slcanfp_rx_if.sv =====
// ---------------------------------------------------------------------------
// Received character channel
// Valid/ready channel carrying one serial character per request.
// ---------------------------------------------------------------------------
interface slcanfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/slcanfp_frame_if.sv =====
// ---------------------------------------------------------------------------
// Decoded frame channel
// Valid/ready channel carrying one parsed CAN frame per request.
// ---------------------------------------------------------------------------
interface slcanfp_frame_if;
	logic        valid;
	logic        ready;
	logic        ext_id;
	logic [31:0] frame_id;
	logic [3:0]  data_length;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;
	logic [7:0]  byte7;
	logic [31:0] frames_seen;

	modport source (
		output valid, output ext_id, output frame_id, output data_length,
		output byte0, output byte1, output byte2, output byte3,
		output byte4, output byte5, output byte6, output byte7,
		output frames_seen, input ready
	);
	modport sink (
		input valid, input ext_id, input frame_id, input data_length,
		input byte0, input byte1, input byte2, input byte3,
		input byte4, input byte5, input byte6, input byte7,
		input frames_seen, output ready
	);
endinterface

// ===== design/slcan_ascii_frame_parser.sv =====
// ---------------------------------------------------------------------------
// Serial CAN ASCII frame parser
// Takes one received character a cycle while not stalled and reports each good frame line.
// ---------------------------------------------------------------------------
// Accepts one character every cycle while the frame output is not stalled;
// a character is registered on entry and parsed from that register once the
// output side is free; a frame closed by CR or LF goes from the line parser
// into the frame output register. The frame output register is the only
// thing that paces input: while a frame waits unread, the character behind
// it waits in the input register and the channel takes at most one more.
// Lines longer than LINE_CAPACITY keep their first LINE_CAPACITY characters.
module slcan_ascii_frame_parser #(
	parameter int LINE_CAPACITY = 63
) (
	input  logic            clk,
	input  logic            arst_n,
	slcanfp_rx_if.sink      rx,
	slcanfp_frame_if.source frame
);
	import slcanfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       step;
	logic       emit;
	result_t    result;

	// Advance the input register whenever the output side can take a frame
	assign rx.ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	slcanfp_line_parser #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (byte_s1),
		.emit   (emit),
		.result (result)
	);

	slcanfp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.result (result),
		.free   (adv),
		.frame  (frame)
	);

endmodule

// ===== design/slcanfp_line_parser.sv =====
// ---------------------------------------------------------------------------
// Line parser
// Holds the per-line field accumulators and updates them one character a
// cycle while step is high; flags a finished frame when a line terminator closes a good line.
// ---------------------------------------------------------------------------
module slcanfp_line_parser #(
	parameter int LINE_CAPACITY = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            ch,
	output logic                  emit,
	output slcanfp_pkg::result_t  result
);
	import slcanfp_pkg::*;

	localparam int PW = $clog2(LINE_CAPACITY + 1);
	localparam logic [PW-1:0] CAP_W      = PW'(LINE_CAPACITY);
	localparam logic [PW-1:0] ID_LEN_STD = PW'(3);
	localparam logic [PW-1:0] ID_LEN_EXT = PW'(8);

	logic [PW-1:0] pos_q, pos_d;
	logic          zero_q, zero_d;
	logic [1:0]    kind_q, kind_d;
	logic [31:0]   id_q, id_d;
	logic          id_stop_q, id_stop_d;
	logic [3:0]    len_q, len_d;
	logic          len_bad_q, len_bad_d;
	logic          len_seen_q, len_seen_d;
	logic [4:0]    pend_q, pend_d;
	data_bytes_t   data_q, data_d;
	logic [31:0]   cnt_q, cnt_d;

	logic [4:0]    hex;
	logic          is_eol;
	logic [PW-1:0] id_len;
	logic [PW-1:0] q;
	logic [PW-2:0] idx;

	// Work out the next line state from the current character
	always_comb begin
		hex    = hex_nibble(ch);
		is_eol = (ch == CH_CR) || (ch == CH_LF);
		id_len = (kind_q == KIND_EXT) ? ID_LEN_EXT : ID_LEN_STD;
		q      = pos_q - id_len - PW'(2);
		idx    = q[PW-1:1];

		emit       = 1'b0;
		pos_d      = pos_q;
		zero_d     = zero_q;
		kind_d     = kind_q;
		id_d       = id_q;
		id_stop_d  = id_stop_q;
		len_d      = len_q;
		len_bad_d  = len_bad_q;
		len_seen_d = len_seen_q;
		pend_d     = pend_q;
		data_d     = data_q;
		cnt_d      = cnt_q;

		if (step) begin
			if (is_eol) begin
				// Close a non-empty line, report it if good, and clear
				if (pos_q != '0) begin
					emit       = (kind_q != KIND_NONE) && len_seen_q && !len_bad_q;
					pos_d      = '0;
					zero_d     = 1'b0;
					kind_d     = KIND_NONE;
					id_d       = '0;
					id_stop_d  = 1'b0;
					len_d      = '0;
					len_bad_d  = 1'b0;
					len_seen_d = 1'b0;
					pend_d     = '0;
					data_d     = '0;
				end
			end else if (pos_q < CAP_W) begin
				pos_d = pos_q + PW'(1);
				if (!zero_q) begin
					if (ch == CH_NUL) begin
						zero_d = 1'b1;
					end else if (pos_q == '0) begin
						case (ch) inside
							CH_T_LO, CH_R_LO: kind_d = KIND_STD;
							CH_T_UP, CH_R_UP: kind_d = KIND_EXT;
							default:          kind_d = KIND_NONE;
						endcase
					end else if (kind_q == KIND_NONE) begin
						kind_d = kind_q;
					end else if (pos_q <= id_len) begin
						// Identifier digits until the first non-hex one
						if (!id_stop_q && hex[4]) begin
							id_d = {id_q[27:0], hex[3:0]};
						end else begin
							id_stop_d = 1'b1;
						end
					end else if (pos_q == id_len + PW'(1)) begin
						len_seen_d = 1'b1;
						if (ch >= CH_0 && ch <= CH_8) begin
							len_d = ch[3:0];
						end else begin
							len_bad_d = 1'b1;
						end
					end else if (len_seen_q && !len_bad_q && (idx < (PW-1)'(len_q))) begin
						// Data pairs: hold the high digit, then write the byte
						if (!q[0]) begin
							pend_d = hex[4] ? hex : 5'd0;
						end else if (pend_q[4]) begin
							data_d[idx[2:0]] = hex[4] ? {pend_q[3:0], hex[3:0]}
								: {4'd0, pend_q[3:0]};
						end else begin
							data_d[idx[2:0]] = 8'd0;
						end
					end
				end
			end
		end

		if (emit) begin
			cnt_d = cnt_q + 32'd1;
		end
	end

	// Result fields as they stand when the terminator arrives
	always_comb begin
		result.ext_id      = (kind_q == KIND_EXT);
		result.frame_id    = id_q;
		result.data_length = len_q;
		result.data_bytes  = data_q;
		result.frames_seen = cnt_q + 32'd1;
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			zero_q     <= 1'b0;
			kind_q     <= KIND_NONE;
			id_q       <= '0;
			id_stop_q  <= 1'b0;
			len_q      <= '0;
			len_bad_q  <= 1'b0;
			len_seen_q <= 1'b0;
			pend_q     <= '0;
			data_q     <= '0;
			cnt_q      <= '0;
		end else begin
			pos_q      <= pos_d;
			zero_q     <= zero_d;
			kind_q     <= kind_d;
			id_q       <= id_d;
			id_stop_q  <= id_stop_d;
			len_q      <= len_d;
			len_bad_q  <= len_bad_d;
			len_seen_q <= len_seen_d;
			pend_q     <= pend_d;
			data_q     <= data_d;
			cnt_q      <= cnt_d;
		end
	end

endmodule

// ===== design/slcanfp_out_stage.sv =====
// ---------------------------------------------------------------------------
// Frame output register
// Holds one decoded frame until the downstream side takes the request.
// ---------------------------------------------------------------------------
module slcanfp_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  slcanfp_pkg::result_t  result,
	output logic                  free,
	slcanfp_frame_if.source       frame
);
	import slcanfp_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Free when empty or being taken this cycle
	assign free = !valid_q || frame.ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frame.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

	// Drive the channel
	assign frame.valid       = valid_q;
	assign frame.ext_id      = res_q.ext_id;
	assign frame.frame_id    = res_q.frame_id;
	assign frame.data_length = res_q.data_length;
	assign frame.byte0       = res_q.data_bytes[0];
	assign frame.byte1       = res_q.data_bytes[1];
	assign frame.byte2       = res_q.data_bytes[2];
	assign frame.byte3       = res_q.data_bytes[3];
	assign frame.byte4       = res_q.data_bytes[4];
	assign frame.byte5       = res_q.data_bytes[5];
	assign frame.byte6       = res_q.data_bytes[6];
	assign frame.byte7       = res_q.data_bytes[7];
	assign frame.frames_seen = res_q.frames_seen;

endmodule

// ===== design/slcanfp_checker.sv =====
// ---------------------------------------------------------------------------
// Frame parser port checker
// Watches the frame channel of the parser and checks its reported frames.
// ---------------------------------------------------------------------------
`include "slcan_ascii_frame_parser_defines.svh"

module slcanfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_valid,
	input logic        frame_ready,
	input logic        ext_id,
	input logic [31:0] frame_id,
	input logic [3:0]  data_length,
	input logic [7:0]  byte7,
	input logic [31:0] frames_seen
);

	// Hold a stalled frame
	`SLCANFP_CHECK_NEXT(a_hold, frame_valid && !frame_ready, frame_valid && $stable(frame_id) && $stable(frames_seen), "stalled frame changed")

	// DLC is never above eight
	`SLCANFP_CHECK(a_dlc, frame_valid, data_length <= 4'd8, "data length above eight")

	// Standard frames carry at most three identifier digits
	`SLCANFP_CHECK(a_std_id, frame_valid && !ext_id, frame_id[31:12] == 20'd0, "standard identifier too wide")

	// Byte 7 stays zero unless the declared length is eight
	`SLCANFP_CHECK(a_tail, frame_valid && (data_length != 4'd8), byte7 == 8'd0, "byte beyond length not zero")

endmodule

bind slcan_ascii_frame_parser slcanfp_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.ext_id      (frame.ext_id),
	.frame_id    (frame.frame_id),
	.data_length (frame.data_length),
	.byte7       (frame.byte7),
	.frames_seen (frame.frames_seen)
);

// ===== bench/slcan_ascii_frame_parser_test.sv =====
// ---------------------------------------------------------------------------
// Serial CAN ASCII frame parser testbench
// Streams directed and random character lines into the parser, predicts each
// good frame with a parser of its own and checks every reported frame field
// by field, under three patterns of idle cycles on the two channels.
// ---------------------------------------------------------------------------
module slcan_ascii_frame_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import slcanfp_pkg::*;

	localparam int          LINE_CAP     = 63;
	localparam int          ITEM_TARGET  = 1450;
	localparam int          DRAIN_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	slcanfp_rx_if    rx_ch ();
	slcanfp_frame_if frame_ch ();

	slcan_ascii_frame_parser #(
		.LINE_CAPACITY(LINE_CAP)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.frame (frame_ch)
	);

	// Characters still to send and frames still owed by the block
	logic [7:0]  char_feed_q[$];
	result_t     frame_due_q[$];
	int unsigned char_total;
	int unsigned chars_taken;
	int unsigned frames_checked;
	int unsigned error_count;
	int unsigned cycle_count;
	bit          rx_busy;

	// Line parser state
	int unsigned line_len;
	bit          nul_hit;
	logic [1:0]  line_kind;
	logic [31:0] id_acc;
	bit          id_done;
	logic [3:0]  dlc_val;
	bit          dlc_bad;
	bit          dlc_got;
	logic [4:0]  hi_nib;
	data_bytes_t data_acc;
	logic [31:0] good_count;

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Value of a hex digit, -1 for any other character
	function automatic int hex_of(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) begin
			return int'(c - CH_0);
		end
		if (c >= CH_A_LO && c <= CH_F_LO) begin
			return int'(c - CH_A_LO) + 10;
		end
		if (c >= CH_A_UP && c <= CH_F_UP) begin
			return int'(c - CH_A_UP) + 10;
		end
		return -1;
	endfunction

	function automatic void clear_line_state();
		line_len  = 0;
		nul_hit   = 1'b0;
		line_kind = KIND_NONE;
		id_acc    = '0;
		id_done   = 1'b0;
		dlc_val   = '0;
		dlc_bad   = 1'b0;
		dlc_got   = 1'b0;
		hi_nib    = '0;
		data_acc  = '0;
	endfunction

	// Fold one stored character at line position p into the frame fields
	function automatic void parse_char(input logic [7:0] c, input int unsigned p);
		int unsigned id_len;
		int unsigned q;
		int unsigned idx;
		int          v;
		v = hex_of(c);
		if (c == CH_NUL) begin
			nul_hit = 1'b1;
			return;
		end
		if (p == 0) begin
			if (c == CH_T_LO || c == CH_R_LO) begin
				line_kind = KIND_STD;
			end else if (c == CH_T_UP || c == CH_R_UP) begin
				line_kind = KIND_EXT;
			end else begin
				line_kind = KIND_NONE;
			end
			return;
		end
		if (line_kind == KIND_NONE) return;
		id_len = (line_kind == KIND_EXT) ? 8 : 3;
		// identifier digits stop at the first non-hex character
		if (p <= id_len) begin
			if (!id_done && v >= 0) begin
				id_acc = {id_acc[27:0], 4'(v)};
			end else begin
				id_done = 1'b1;
			end
			return;
		end
		if (p == id_len + 1) begin
			dlc_got = 1'b1;
			if (c >= CH_0 && c <= CH_8) begin
				dlc_val = 4'(c - CH_0);
			end else begin
				dlc_bad = 1'b1;
			end
			return;
		end
		if (!dlc_got || dlc_bad) return;
		q   = p - id_len - 2;
		idx = q / 2;
		if (idx >= dlc_val || idx >= NUM_DATA) return;
		// data pairs: first half latched, second half completes the byte
		if (q % 2 == 0) begin
			hi_nib = (v >= 0) ? {1'b1, 4'(v)} : 5'd0;
		end else if (hi_nib[4]) begin
			data_acc[idx] = (v >= 0) ? {hi_nib[3:0], 4'(v)} : {4'h0, hi_nib[3:0]};
		end else begin
			data_acc[idx] = '0;
		end
	endfunction

	// Advance the line on one accepted character; queue a frame on a good line end
	function automatic void predict_char(input logic [7:0] c);
		result_t r;
		if (c == CH_CR || c == CH_LF) begin
			if (line_len > 0) begin
				if (line_kind != KIND_NONE && dlc_got && !dlc_bad) begin
					good_count    = good_count + 1;
					r.ext_id      = (line_kind == KIND_EXT);
					r.frame_id    = id_acc;
					r.data_length = dlc_val;
					r.data_bytes  = data_acc;
					r.frames_seen = good_count;
					frame_due_q.push_back(r);
				end
				clear_line_state();
			end
		end else if (line_len < LINE_CAP) begin
			if (!nul_hit) parse_char(c, line_len);
			line_len++;
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("frame %0d: %s got %h want %h", frames_checked, field, got, want);
		error_count++;
	endtask

	// Compare one reported frame with the oldest one owed
	task automatic check_frame();
		result_t     want;
		data_bytes_t got;
		got = {frame_ch.byte7, frame_ch.byte6, frame_ch.byte5, frame_ch.byte4,
			frame_ch.byte3, frame_ch.byte2, frame_ch.byte1, frame_ch.byte0};
		if (frame_due_q.size() == 0) begin
			report_mismatch("unexpected frame, count", frame_ch.frames_seen, '0);
		end else begin
			want = frame_due_q.pop_front();
			if (frame_ch.ext_id !== want.ext_id)
				report_mismatch("ext_id", frame_ch.ext_id, want.ext_id);
			if (frame_ch.frame_id !== want.frame_id)
				report_mismatch("frame_id", frame_ch.frame_id, want.frame_id);
			if (frame_ch.data_length !== want.data_length)
				report_mismatch("data_length", frame_ch.data_length, want.data_length);
			for (int i = 0; i < NUM_DATA; i++) begin
				if (got[i] !== want.data_bytes[i])
					report_mismatch($sformatf("byte%0d", i), got[i], want.data_bytes[i]);
			end
			if (frame_ch.frames_seen !== want.frames_seen)
				report_mismatch("frames_seen", frame_ch.frames_seen, want.frames_seen);
		end
		frames_checked++;
	endtask

	// Idle percentage of either side for the current third of the run
	function automatic int idle_pct(input bit sender);
		int unsigned third;
		third = (char_total == 0) ? 2 : chars_taken * 3 / char_total;
		if (third == 0) return sender ? 16 : 71;
		if (third == 1) return sender ? 71 : 16;
		return 0;
	endfunction

	function automatic logic [7:0] rand_hex();
		int unsigned k;
		k = $urandom_range(0, 21);
		if (k < 10) return CH_0 + 8'(k);
		if (k < 16) return CH_A_LO + 8'(k - 10);
		return CH_A_UP + 8'(k - 16);
	endfunction

	// Any character other than a line end or a zero byte
	function automatic logic [7:0] rand_junk();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(1, 255));
		end while (c == CH_CR || c == CH_LF);
		return c;
	endfunction

	function automatic logic [7:0] rand_eol();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) char_feed_q.push_back(s[i]);
	endfunction

	// Mostly well-formed frame lines with random content, plus noise and empty lines
	function automatic void push_random_line();
		logic [7:0]  text_q[$];
		int unsigned pick;
		int unsigned id_len;
		int unsigned dlc;
		int unsigned pairs;
		int unsigned target;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			char_feed_q.push_back(rand_eol());
			return;
		end
		if (pick < 20) begin
			repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0:       text_q.push_back(CH_T_LO);
				1:       text_q.push_back(CH_R_LO);
				2:       text_q.push_back(CH_T_UP);
				default: text_q.push_back(CH_R_UP);
			endcase
			id_len = (text_q[0] == CH_T_UP || text_q[0] == CH_R_UP) ? 8 : 3;
			repeat (id_len) text_q.push_back(($urandom_range(0, 29) == 0) ? rand_junk() : rand_hex());
			// drop the line short of its DLC now and then
			if ($urandom_range(0, 24) == 0) begin
				repeat ($urandom_range(0, id_len)) void'(text_q.pop_back());
			end else begin
				dlc = $urandom_range(0, 8);
				case ($urandom_range(0, 19))
					0:       text_q.push_back(rand_junk());
					1:       text_q.push_back(CH_9);
					default: text_q.push_back(CH_0 + 8'(dlc));
				endcase
				pairs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 9) : dlc;
				repeat (2 * pairs) begin
					text_q.push_back(($urandom_range(0, 24) == 0) ? rand_junk() : rand_hex());
				end
				if ($urandom_range(0, 7) == 0) text_q.push_back(rand_hex());
			end
			if ($urandom_range(0, 14) == 0) begin
				text_q[$urandom_range(0, text_q.size() - 1)] = CH_NUL;
			end
			// run past the line capacity now and then
			if ($urandom_range(0, 19) == 0) begin
				target = $urandom_range(LINE_CAP - 2, LINE_CAP + 25);
				while (text_q.size() < target) text_q.push_back(rand_hex());
			end
		end
		foreach (text_q[i]) char_feed_q.push_back(text_q[i]);
		char_feed_q.push_back(rand_eol());
	endfunction

	// Offer the next request at the falling edge; hold it until taken
	always @(negedge clk) begin
		if (arst_n === 1'b1 && !rx_busy) begin
			if (char_feed_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
				rx_ch.valid   <= 1'b1;
				rx_ch.rx_byte <= char_feed_q.pop_front();
				rx_busy = 1'b1;
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// Stall the frame channel at random
	always @(negedge clk) begin
		frame_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) begin
				predict_char(rx_ch.rx_byte);
				chars_taken++;
				rx_busy = 1'b0;
			end
			if (frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) check_frame();
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("slcan_ascii_frame_parser_test: errors");
			$finish;
		end
	end

	initial begin
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		frame_ch.ready = 1'b0;
		rx_busy        = 1'b0;
		chars_taken    = 0;
		char_total     = 0;
		frames_checked = 0;
		error_count    = 0;
		cycle_count    = 0;
		good_count     = '0;
		clear_line_state();

		// empty line, smallest frame, widest identifier with a lone data byte
		push_text("\r");
		push_text("t7FF0\n");
		push_text("TFFFFFFFF1ff\r");
		// identifier cut short, incomplete final pair
		push_text("r0g22a\n");
		// unknown type, too short, DLC out of range
		push_text("x\r");
		push_text("t1\r");
		push_text("t0009\r");
		while (char_feed_q.size() < ITEM_TARGET) push_random_line();
		char_total = char_feed_q.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: everything sent, every owed frame seen
		while (char_feed_q.size() > 0 || rx_busy || frame_due_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && frame_due_q.size() == 0) begin
			$display("slcan_ascii_frame_parser_test: clean");
		end else begin
			$display("slcan_ascii_frame_parser_test: errors");
		end
		$finish;
	end

endmodule
